### src/wdle_pkg.sv
// Shared types, constants and hash functions for the wiki dump link extractor.
// No dependencies; the front end, back end, top and testbench use scoped names.
package wdle_pkg;

	// result kinds
	localparam logic [1:0] KIND_TITLE = 2'd0;
	localparam logic [1:0] KIND_LINK  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// pattern identifiers for tag and prefix matching
	localparam logic [2:0] PAT_PAGE  = 3'd0;
	localparam logic [2:0] PAT_TITLE = 3'd1;
	localparam logic [2:0] PAT_TEXT  = 3'd2;
	localparam logic [2:0] PAT_CAT   = 3'd3;
	localparam logic [2:0] PAT_IMG   = 3'd4;
	localparam logic [2:0] PAT_FILE  = 3'd5;

	localparam logic [7:0] CH_LT   = 8'h3C; // <
	localparam logic [7:0] CH_GT   = 8'h3E; // >
	localparam logic [7:0] CH_LBR  = 8'h5B; // [
	localparam logic [7:0] CH_RBR  = 8'h5D; // ]
	localparam logic [7:0] CH_PIPE = 8'h7C; // |

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// one queue entry: what the back end does with the hash for one byte
	typedef struct packed {
		logic        clr;       // zero the hash first
		logic        hash_br;   // fold in a held-back ']'
		logic        hash_byte; // fold in data
		logic        emit;      // deliver a result
		logic [1:0]  kind;
		logic [15:0] len;
		logic [7:0]  data;
	} cmd_t;

	function automatic logic [3:0] pat_len(logic [2:0] id);
		logic [3:0] n;
		begin
			case (id)
				PAT_PAGE:  n = 4'd5;
				PAT_TITLE: n = 4'd6;
				PAT_TEXT:  n = 4'd5;
				PAT_CAT:   n = 4'd9;
				PAT_IMG:   n = 4'd6;
				PAT_FILE:  n = 4'd5;
				default:   n = 4'd0;
			endcase
			return n;
		end
	endfunction

	function automatic logic [7:0] pat_char(logic [2:0] id, logic [3:0] p);
		logic [71:0] s;
		logic [7:0]  ch;
		begin
			// patterns left-aligned, first character in the top byte
			case (id)
				PAT_PAGE:  s = {"<page", 32'd0};
				PAT_TITLE: s = {"<title", 24'd0};
				PAT_TEXT:  s = {"<text", 32'd0};
				PAT_CAT:   s = "Category:";
				PAT_IMG:   s = {"Image:", 24'd0};
				PAT_FILE:  s = {"File:", 32'd0};
				default:   s = 72'd0;
			endcase
			case (p)
				4'd0: ch = s[71:64];
				4'd1: ch = s[63:56];
				4'd2: ch = s[55:48];
				4'd3: ch = s[47:40];
				4'd4: ch = s[39:32];
				4'd5: ch = s[31:24];
				4'd6: ch = s[23:16];
				4'd7: ch = s[15:8];
				4'd8: ch = s[7:0];
				default: ch = 8'h00;
			endcase
			return ch;
		end
	endfunction

	// byte b extends the match of pattern id at position p
	function automatic logic pat_hit(logic [2:0] id, logic [3:0] p, logic [7:0] b);
		return (p < pat_len(id)) && (b == pat_char(id, p));
	endfunction

	function automatic logic [5:0] hash_digit(logic [7:0] c);
		logic [7:0] f;
		logic [7:0] r;
		logic [5:0] d;
		begin
			f = c;
			if (c >= 8'd65 && c <= 8'd90) f = c + 8'd32;
			r = f;
			if (r >= 8'd144) r = r - 8'd144;
			if (r >= 8'd72) r = r - 8'd72;
			if (r >= 8'd36) r = r - 8'd36;
			if (f >= 8'd97 && f <= 8'd122) d = 6'(f - 8'd96);
			else if (f >= 8'd48 && f <= 8'd56) d = 6'(f - 8'd21);
			else if (f == 8'd57) d = 6'd36;
			else if (f == 8'd46) d = 6'd37;
			else d = r[5:0];
			return d;
		end
	endfunction

	// h * 38 + digit, mod 2^64
	function automatic logic [63:0] hash_step(logic [63:0] h, logic [7:0] c);
		return (h << 5) + (h << 2) + (h << 1) + {58'd0, hash_digit(c)};
	endfunction

endpackage

### src/wdle_dump_if.sv
// Byte input channel of the link extractor: valid/ready plus one dump byte
// and the new_file flag. No dependencies.
interface wdle_dump_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       new_file;

	modport source(output valid, output text_byte, output new_file, input ready);
	modport sink(input valid, input text_byte, input new_file, output ready);
endinterface

### src/wdle_result_if.sv
// Result channel of the link extractor: valid/ready plus kind, hash and title length.
// No dependencies.
interface wdle_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] digest;
	logic [15:0] title_length;

	modport source(output valid, output kind, output digest, output title_length,
		input ready);
	modport sink(input valid, input kind, input digest, input title_length,
		output ready);
endinterface

### src/wdle_queue.sv
// Small register FIFO between the parser and the hash back end.
// No package dependencies.
module wdle_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  logic [WIDTH-1:0] wr_data,
	output logic             wr_ready,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	input  logic             rd_pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != FULL);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### src/wdle_front.sv
// Parser front end: tracks page, title, text and link context one byte per clock while
// the queue has room, and turns each byte into a hash command. Uses wdle_pkg and wdle_dump_if.
module wdle_front (
	input  logic              clk,
	input  logic              arst_n,
	wdle_dump_if.sink         dump,
	input  logic              q_ready,
	output logic              q_push,
	output wdle_pkg::cmd_t    q_cmd
);
	localparam logic [2:0] MODE_SEEK_PAGE  = 3'd0;
	localparam logic [2:0] MODE_SEEK_TITLE = 3'd1;
	localparam logic [2:0] MODE_SEEK_GT    = 3'd2;
	localparam logic [2:0] MODE_TITLE      = 3'd3;
	localparam logic [2:0] MODE_SEEK_TEXT  = 3'd4;
	localparam logic [2:0] MODE_TEXT       = 3'd5;
	localparam logic [2:0] MODE_LINK       = 3'd6;

	logic [2:0]  mode_q, mode_d;
	logic [3:0]  pos_q, pos_d;
	logic [2:0]  pfx_q, pfx_d;
	logic        pend_q, pend_d;
	logic        prev_lbr_q, prev_lbr_d;
	logic [15:0] count_q, count_d;

	logic        accept;
	logic [7:0]  b;
	logic [2:0]  m;
	logic [3:0]  p;
	logic [3:0]  p1;
	logic [2:0]  c;
	logic        done;
	wdle_pkg::cmd_t cmd;

	assign accept     = dump.valid && dump.ready;
	assign dump.ready = q_ready;
	assign b          = dump.text_byte;
	assign q_cmd      = cmd;
	assign q_push     = accept && (cmd.clr || cmd.hash_br || cmd.hash_byte || cmd.emit);

	always_comb begin
		// a new file starts from the cleared state
		m          = dump.new_file ? MODE_SEEK_PAGE : mode_q;
		mode_d     = m;
		pos_d      = dump.new_file ? 4'd0 : pos_q;
		pfx_d      = dump.new_file ? 3'd0 : pfx_q;
		pend_d     = dump.new_file ? 1'b0 : pend_q;
		prev_lbr_d = dump.new_file ? 1'b0 : prev_lbr_q;
		count_d    = dump.new_file ? 16'd0 : count_q;
		p          = pos_d;
		p1         = p + 4'd1;
		c          = pfx_d;
		done       = 1'b0;
		cmd        = '0;
		cmd.data   = b;

		case (m)
			MODE_SEEK_TITLE: begin
				if (wdle_pkg::pat_hit(wdle_pkg::PAT_TITLE, p, b)) begin
					if (p1 == wdle_pkg::pat_len(wdle_pkg::PAT_TITLE)) begin
						pos_d  = 4'd0;
						mode_d = MODE_SEEK_GT;
					end else begin
						pos_d = p1;
					end
				end else begin
					pos_d = (b == wdle_pkg::CH_LT) ? 4'd1 : 4'd0;
				end
			end
			MODE_SEEK_GT: begin
				if (b == wdle_pkg::CH_GT) begin
					mode_d  = MODE_TITLE;
					count_d = 16'd0;
					cmd.clr = 1'b1;
				end
			end
			MODE_TITLE: begin
				if (b == wdle_pkg::CH_LT) begin
					cmd.emit = 1'b1;
					cmd.kind = wdle_pkg::KIND_TITLE;
					cmd.len  = count_d;
					mode_d   = MODE_SEEK_TEXT;
					pos_d    = 4'd0;
					count_d  = 16'd0;
				end else begin
					cmd.hash_byte = 1'b1;
					if (count_d != wdle_pkg::COUNT_MAX) begin
						count_d = count_d + 16'd1;
					end
				end
			end
			MODE_SEEK_TEXT: begin
				if (wdle_pkg::pat_hit(wdle_pkg::PAT_TEXT, p, b)) begin
					if (p1 == wdle_pkg::pat_len(wdle_pkg::PAT_TEXT)) begin
						mode_d     = MODE_TEXT;
						pos_d      = 4'd0;
						pfx_d      = 3'd0;
						pend_d     = 1'b0;
						prev_lbr_d = 1'b0;
					end else begin
						pos_d = p1;
					end
				end else begin
					pos_d = (b == wdle_pkg::CH_LT) ? 4'd1 : 4'd0;
				end
			end
			MODE_TEXT: begin
				if (b == wdle_pkg::CH_LT) begin
					cmd.emit   = 1'b1;
					cmd.kind   = wdle_pkg::KIND_END;
					mode_d     = MODE_SEEK_PAGE;
					pos_d      = 4'd0;
					pfx_d      = 3'd0;
					pend_d     = 1'b0;
					prev_lbr_d = 1'b0;
					count_d    = 16'd0;
				end else if (b == wdle_pkg::CH_LBR && prev_lbr_d) begin
					mode_d     = MODE_LINK;
					pos_d      = 4'd0;
					pfx_d      = 3'b111;
					pend_d     = 1'b0;
					prev_lbr_d = 1'b0;
					cmd.clr    = 1'b1;
				end else begin
					prev_lbr_d = (b == wdle_pkg::CH_LBR);
				end
			end
			MODE_LINK: begin
				if (b == wdle_pkg::CH_LT) begin
					// a tag inside a link ends the page text
					cmd.emit   = 1'b1;
					cmd.kind   = wdle_pkg::KIND_END;
					mode_d     = MODE_SEEK_PAGE;
					pos_d      = 4'd0;
					pfx_d      = 3'd0;
					pend_d     = 1'b0;
					prev_lbr_d = 1'b0;
					count_d    = 16'd0;
				end else begin
					if (pend_d) begin
						pend_d = 1'b0;
						if (b == wdle_pkg::CH_RBR) begin
							cmd.emit = 1'b1;
							cmd.kind = wdle_pkg::KIND_LINK;
							done     = 1'b1;
						end else begin
							cmd.hash_br = 1'b1;
						end
					end
					if (!done && b == wdle_pkg::CH_PIPE) begin
						cmd.emit = 1'b1;
						cmd.kind = wdle_pkg::KIND_LINK;
						done     = 1'b1;
					end
					if (done) begin
						mode_d     = MODE_TEXT;
						pos_d      = 4'd0;
						pfx_d      = 3'd0;
						prev_lbr_d = 1'b0;
					end else if (b == wdle_pkg::CH_RBR) begin
						// hold the bracket until the next byte shows whether it closes
						pend_d = 1'b1;
						pfx_d  = 3'd0;
					end else begin
						cmd.hash_byte = 1'b1;
						if (c != 3'd0) begin
							if (c[0] && !wdle_pkg::pat_hit(wdle_pkg::PAT_CAT, p, b)) c[0] = 1'b0;
							if (c[1] && !wdle_pkg::pat_hit(wdle_pkg::PAT_IMG, p, b)) c[1] = 1'b0;
							if (c[2] && !wdle_pkg::pat_hit(wdle_pkg::PAT_FILE, p, b)) c[2] = 1'b0;
							pfx_d = c;
							pos_d = (c != 3'd0) ? p1 : 4'd0;
							if (c[0] && p1 == wdle_pkg::pat_len(wdle_pkg::PAT_CAT)) begin
								cmd.emit   = 1'b1;
								cmd.kind   = wdle_pkg::KIND_END;
								mode_d     = MODE_SEEK_PAGE;
								pos_d      = 4'd0;
								pfx_d      = 3'd0;
								prev_lbr_d = 1'b0;
								count_d    = 16'd0;
							end else if ((c[1] && p1 == wdle_pkg::pat_len(wdle_pkg::PAT_IMG))
								|| (c[2] && p1 == wdle_pkg::pat_len(wdle_pkg::PAT_FILE))) begin
								mode_d     = MODE_TEXT;
								pos_d      = 4'd0;
								pfx_d      = 3'd0;
								prev_lbr_d = 1'b0;
							end
						end
					end
				end
			end
			default: begin
				mode_d = MODE_SEEK_PAGE;
				if (wdle_pkg::pat_hit(wdle_pkg::PAT_PAGE, p, b)) begin
					if (p1 == wdle_pkg::pat_len(wdle_pkg::PAT_PAGE)) begin
						pos_d  = 4'd0;
						mode_d = MODE_SEEK_TITLE;
					end else begin
						pos_d = p1;
					end
				end else begin
					pos_d = (b == wdle_pkg::CH_LT) ? 4'd1 : 4'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SEEK_PAGE;
			pos_q      <= 4'd0;
			pfx_q      <= 3'd0;
			pend_q     <= 1'b0;
			prev_lbr_q <= 1'b0;
			count_q    <= 16'd0;
		end else if (accept) begin
			mode_q     <= mode_d;
			pos_q      <= pos_d;
			pfx_q      <= pfx_d;
			pend_q     <= pend_d;
			prev_lbr_q <= prev_lbr_d;
			count_q    <= count_d;
		end
	end
endmodule

### src/wdle_back.sv
// Hash back end: applies queued commands to the running base-38 hash and
// drives the registered result channel. Uses wdle_pkg and wdle_result_if.
module wdle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  wdle_pkg::cmd_t    head,
	output logic              pop,
	wdle_result_if.source     result
);
	logic [63:0] hash_q, hash_d;
	logic        br_done_q, br_done_d;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [63:0] value_q;
	logic [15:0] len_q;
	logic [63:0] h_base;
	logic        out_free;
	logic        load_out;

	assign h_base   = head.clr ? 64'd0 : hash_q;
	assign out_free = !out_valid_q || result.ready;
	assign load_out = pop && head.emit;

	assign result.valid        = out_valid_q;
	assign result.kind         = kind_q;
	assign result.digest       = value_q;
	assign result.title_length = len_q;

	always_comb begin
		pop       = 1'b0;
		hash_d    = hash_q;
		br_done_d = br_done_q;
		if (head_valid) begin
			if (head.hash_br && !br_done_q) begin
				// fold the held-back bracket first, keep the entry for the byte
				hash_d    = wdle_pkg::hash_step(h_base, wdle_pkg::CH_RBR);
				br_done_d = 1'b1;
			end else if (!head.emit || out_free) begin
				pop       = 1'b1;
				br_done_d = 1'b0;
				hash_d    = head.hash_byte ? wdle_pkg::hash_step(h_base, head.data) : h_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q  <= head.kind;
			value_q <= (head.kind == wdle_pkg::KIND_END) ? 64'd0 : h_base;
			len_q   <= (head.kind == wdle_pkg::KIND_TITLE) ? head.len : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= 64'd0;
			br_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hash_q    <= hash_d;
			br_done_q <= br_done_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### src/wiki_dump_link_extractor.sv
// Top level of the wiki dump link extractor: parser front end, command queue,
// hash back end. Uses wdle_pkg, wdle_dump_if, wdle_result_if and the three submodules.
//
// Takes one dump byte per clock whenever the command queue (QUEUE_DEPTH entries) has
// room and emits title hashes, link hashes and page-end markers. The parser decides
// every byte combinationally; the back end folds one byte into the 64-bit hash per
// cycle while no result waits for the output register, except that a byte following
// a lone ']' inside a link is folded as the held bracket first and then the byte.
// A result is registered: the command for the byte that caused it passes through the
// queue into the back end's output register; the queue absorbs result stalls before
// input is held off.
module wiki_dump_link_extractor #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	wdle_dump_if.sink     dump,
	wdle_result_if.source result
);
	localparam int CMD_W = $bits(wdle_pkg::cmd_t);

	logic             q_ready;
	logic             q_push;
	wdle_pkg::cmd_t   q_cmd;
	logic             head_valid;
	logic [CMD_W-1:0] head_bits;
	wdle_pkg::cmd_t   head;
	logic             pop;

	assign head = wdle_pkg::cmd_t'(head_bits);

	wdle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.dump    (dump),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	wdle_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_push),
		.wr_data  (CMD_W'(q_cmd)),
		.wr_ready (q_ready),
		.rd_valid (head_valid),
		.rd_data  (head_bits),
		.rd_pop   (pop)
	);

	wdle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);
endmodule

### tb/tb_wiki_dump_link_extractor.sv
// Self-checking testbench for wiki_dump_link_extractor: directed table plus random dump pages.
// Depends on wdle_pkg, wdle_dump_if, wdle_result_if and the extractor RTL.
`timescale 1ns / 100ps

module tb_wiki_dump_link_extractor;

	localparam int RANDOM_ITEMS     = 1450;
	localparam int STALL_LIMIT      = 500;
	localparam int DRAIN_CYCLES     = 20;
	localparam int MAX_REPORTS      = 10;
	localparam int PFX_CATEGORY     = 1;

	localparam string PAGE_TAG     = "<page";
	localparam string TITLE_TAG    = "<title";
	localparam string TEXT_TAG     = "<text";
	localparam string CATEGORY_PFX = "Category:";
	localparam string IMAGE_PFX    = "Image:";
	localparam string FILE_PFX     = "File:";

	localparam string TITLE_CHARS = "ABCMXYZabcmxyz0189._ :()-";
	localparam string TEXT_CHARS  = "abcXYZ 019.,[]|:-'";
	localparam string LINK_CHARS  = "abcqXYZ0589. _:]]-[";

	typedef enum logic [3:0] {
		SEEK_PAGE  = 4'd0,
		SEEK_TITLE = 4'd1,
		SEEK_GT    = 4'd2,
		IN_TITLE   = 4'd3,
		SEEK_TEXT  = 4'd4,
		IN_TEXT    = 4'd5,
		IN_LINK    = 4'd6
	} scan_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] digest;
		logic [15:0] title_length;
	} link_rec_t;

	typedef struct {
		logic [7:0] data;
		logic       nf;
		bit         calm;
		bit         typed;
		link_rec_t  want;
	} dump_item_t;

	typedef struct {
		string      seg;
		logic [7:0] raw;
		logic       nf;
		bit         typed;
		link_rec_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	wdle_dump_if   dump_ch();
	wdle_result_if result_ch();

	wiki_dump_link_extractor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.dump   (dump_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// parser state of the predictor
	scan_state_t scan_state;
	logic [3:0]  scan_pos;
	logic [63:0] scan_hash;
	logic [7:0]  scan_prev;
	logic [2:0]  scan_cand;
	logic        scan_held;
	logic [15:0] scan_count;

	dump_item_t dump_q[$];
	link_rec_t  pending_results[$];

	bit  gen_calm;
	int  gen_count;
	bit  calm_now;
	int  sink_hold = 0;
	int  fault_count = 0;
	int  bytes_in;
	int  titles_seen = 0;
	int  links_seen = 0;
	int  ends_seen = 0;
	int  longest_title = 0;
	link_rec_t want_rec;

	string link_prefixes[8] = '{"", "Category:", "Image:", "File:", "Cat", "file:",
		"Imag", "Categ"};

	stim_row_t directed_rows[9] = '{
		'{"",       8'h00, 1'b1, 1'b0, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"",       8'hFF, 1'b0, 1'b0, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"<<page", 8'h00, 1'b0, 1'b0, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"<title>", 8'h00, 1'b0, 1'b0, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"<",      8'h00, 1'b0, 1'b1, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"<text",  8'h00, 1'b0, 1'b0, '{wdle_pkg::KIND_TITLE, 64'd0, 16'd0}},
		'{"[[]]",   8'h00, 1'b0, 1'b1, '{wdle_pkg::KIND_LINK, 64'd0, 16'd0}},
		'{"[[|",    8'h00, 1'b0, 1'b1, '{wdle_pkg::KIND_LINK, 64'd0, 16'd0}},
		'{"<",      8'h00, 1'b0, 1'b1, '{wdle_pkg::KIND_END, 64'd0, 16'd0}}
	};

	function automatic logic [63:0] base38_digit(input logic [7:0] c);
		logic [7:0] f;
		f = c;
		if (f >= "A" && f <= "Z") f = f + 8'd32;
		if (f >= "a" && f <= "z") return 64'(f - 8'd96);
		if (f >= "0" && f <= "8") return 64'(f - "0" + 8'd27);
		if (f == "9") return 64'd36;
		if (f == ".") return 64'd37;
		return 64'(f % 8'd36);
	endfunction

	function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] c);
		return h * 64'd38 + base38_digit(c);
	endfunction

	function automatic void clear_scan();
		scan_state = SEEK_PAGE;
		scan_pos   = 4'd0;
		scan_hash  = 64'd0;
		scan_prev  = 8'd0;
		scan_cand  = 3'd0;
		scan_held  = 1'b0;
		scan_count = 16'd0;
	endfunction

	function automatic void enter_text();
		scan_state = IN_TEXT;
		scan_prev  = 8'd0;
		scan_pos   = 4'd0;
		scan_cand  = 3'd0;
		scan_held  = 1'b0;
		scan_hash  = 64'd0;
	endfunction

	// advance a tag match; a mismatching '<' starts a new match
	function automatic bit tag_step(input string pat, input logic [7:0] b);
		int p;
		p = scan_pos;
		if (p < pat.len() && b == pat[p]) begin
			p++;
			if (p >= pat.len()) begin
				scan_pos = 4'd0;
				return 1'b1;
			end
			scan_pos = 4'(p);
			return 1'b0;
		end
		scan_pos = (b == wdle_pkg::CH_LT) ? 4'd1 : 4'd0;
		return 1'b0;
	endfunction

	task automatic extract_step(input logic [7:0] b, input logic nf, output logic fire,
		output link_rec_t rec);
		int p;
		logic [2:0] c;
		fire = 1'b0;
		rec = '0;
		if (nf) clear_scan();
		case (scan_state)
			SEEK_TITLE: if (tag_step(TITLE_TAG, b)) scan_state = SEEK_GT;
			SEEK_GT: if (b == wdle_pkg::CH_GT) begin
				scan_state = IN_TITLE;
				scan_hash = 64'd0;
				scan_count = 16'd0;
			end
			IN_TITLE: if (b == wdle_pkg::CH_LT) begin
				fire = 1'b1;
				rec = '{wdle_pkg::KIND_TITLE, scan_hash, scan_count};
				scan_state = SEEK_TEXT;
				scan_pos = 4'd0;
				scan_hash = 64'd0;
				scan_count = 16'd0;
			end else begin
				scan_hash = fold_byte(scan_hash, b);
				if (scan_count != wdle_pkg::COUNT_MAX) scan_count = scan_count + 16'd1;
			end
			SEEK_TEXT: if (tag_step(TEXT_TAG, b)) enter_text();
			IN_TEXT: if (b == wdle_pkg::CH_LT) begin
				clear_scan();
				fire = 1'b1;
				rec = '{wdle_pkg::KIND_END, 64'd0, 16'd0};
			end else if (b == wdle_pkg::CH_LBR && scan_prev == wdle_pkg::CH_LBR) begin
				scan_state = IN_LINK;
				scan_hash = 64'd0;
				scan_pos = 4'd0;
				scan_cand = 3'b111;
				scan_held = 1'b0;
				scan_prev = 8'd0;
			end else begin
				scan_prev = b;
			end
			IN_LINK: if (b == wdle_pkg::CH_LT) begin
				// drop the link, close the page
				clear_scan();
				fire = 1'b1;
				rec = '{wdle_pkg::KIND_END, 64'd0, 16'd0};
			end else if (scan_held && b == wdle_pkg::CH_RBR) begin
				fire = 1'b1;
				rec = '{wdle_pkg::KIND_LINK, scan_hash, 16'd0};
				enter_text();
			end else begin
				if (scan_held) begin
					scan_held = 1'b0;
					scan_hash = fold_byte(scan_hash, wdle_pkg::CH_RBR);
				end
				if (b == wdle_pkg::CH_PIPE) begin
					fire = 1'b1;
					rec = '{wdle_pkg::KIND_LINK, scan_hash, 16'd0};
					enter_text();
				end else if (b == wdle_pkg::CH_RBR) begin
					scan_held = 1'b1;
					scan_cand = 3'd0;
				end else begin
					scan_hash = fold_byte(scan_hash, b);
					if (scan_cand != 3'd0) begin
						p = scan_pos;
						c = scan_cand;
						if (c[0] && !(p < CATEGORY_PFX.len() && b == CATEGORY_PFX[p])) c[0] = 1'b0;
						if (c[1] && !(p < IMAGE_PFX.len() && b == IMAGE_PFX[p])) c[1] = 1'b0;
						if (c[2] && !(p < FILE_PFX.len() && b == FILE_PFX[p])) c[2] = 1'b0;
						p++;
						scan_cand = c;
						scan_pos = (c != 3'd0) ? 4'(p) : 4'd0;
						if (c[0] && p == CATEGORY_PFX.len()) begin
							clear_scan();
							fire = 1'b1;
							rec = '{wdle_pkg::KIND_END, 64'd0, 16'd0};
						end else if ((c[1] && p == IMAGE_PFX.len()) ||
							(c[2] && p == FILE_PFX.len())) begin
							enter_text();
						end
					end
				end
			end
			default: begin
				scan_state = SEEK_PAGE;
				if (tag_step(PAGE_TAG, b)) scan_state = SEEK_TITLE;
			end
		endcase
	endtask

	function automatic logic [7:0] pick_char(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task automatic push_byte(input logic [7:0] b);
		dump_item_t it;
		it.data  = b;
		it.nf    = !gen_calm && ($urandom_range(0, 299) == 0);
		it.calm  = gen_calm;
		it.typed = 1'b0;
		it.want  = '0;
		dump_q.insert(dump_q.size(), it);
		gen_count++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	// one page of dump text, mostly well formed, with near-miss tags and noise
	task automatic build_page();
		int n;
		int pieces;
		int pfx;
		int term;
		logic [7:0] b;
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 7) == 0) push_text("<pag");
		push_text("<page>\n ");
		if ($urandom_range(0, 7) == 0) push_text("<tit");
		push_text(TITLE_TAG);
		if ($urandom_range(0, 3) == 0) push_text(" lang=\"en\"");
		push_byte(wdle_pkg::CH_GT);
		n = $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				b = 8'($urandom_range(0, 255));
				if (b == wdle_pkg::CH_LT) b = wdle_pkg::CH_GT;
				push_byte(b);
			end else begin
				push_byte(pick_char(TITLE_CHARS));
			end
		end
		push_byte(wdle_pkg::CH_LT);
		push_text("/title><id>7</id>");
		if ($urandom_range(0, 7) == 0) push_text("<te");
		push_text(TEXT_TAG);
		push_text(" xml:space=\"preserve\">");
		pieces = $urandom_range(0, 6);
		for (int k = 0; k < pieces; k++) begin
			if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) push_byte(pick_char(TEXT_CHARS));
			end else begin
				push_text("[[");
				pfx = $urandom_range(0, 7);
				push_text(link_prefixes[pfx]);
				// a category link closes the page
				if (pfx == PFX_CATEGORY) return;
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++) push_byte(pick_char(LINK_CHARS));
				term = $urandom_range(0, 11);
				if (term == 0) begin
					push_byte(wdle_pkg::CH_LT);
					return;
				end else if (term <= 4) begin
					push_byte(wdle_pkg::CH_PIPE);
					n = $urandom_range(0, 5);
					for (int i = 0; i < n; i++) push_byte(pick_char(TEXT_CHARS));
					push_text("]]");
				end else begin
					push_text("]]");
				end
			end
		end
		push_byte(wdle_pkg::CH_LT);
		push_text("/text></revision></page>\n");
	endtask

	// result sink: compare each transaction, then hold ready low for a random stretch unless calm
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result: kind %0d hash %h length %0d", result_ch.kind,
						result_ch.digest, result_ch.title_length);
			end else begin
				want_rec = pending_results.pop_front();
				if (result_ch.kind !== want_rec.kind ||
					result_ch.digest !== want_rec.digest ||
					result_ch.title_length !== want_rec.title_length) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("mismatch: kind %0d/%0d hash %h/%h length %0d/%0d (exp/got)",
							want_rec.kind, result_ch.kind, want_rec.digest,
							result_ch.digest, want_rec.title_length,
							result_ch.title_length);
				end
			end
			case (result_ch.kind)
				wdle_pkg::KIND_TITLE: begin
					titles_seen++;
					if (result_ch.title_length > longest_title)
						longest_title = result_ch.title_length;
				end
				wdle_pkg::KIND_LINK: links_seen++;
				default: ends_seen++;
			endcase
			sink_hold = calm_now ? 0 : $urandom_range(0, 18);
			if (sink_hold != 0) result_ch.ready <= 1'b0;
		end else if (!result_ch.ready) begin
			if (sink_hold <= 1) result_ch.ready <= 1'b1;
			sink_hold--;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((dump_ch.valid && dump_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("wiki_dump_link_extractor test failed");
		$finish;
	end

	initial begin : stimulus
		dump_item_t item;
		int n;
		int gap;
		logic fire;
		link_rec_t rec;

		arst_n <= 1'b0;
		dump_ch.valid <= 1'b0;
		dump_ch.text_byte <= 8'd0;
		dump_ch.new_file <= 1'b0;
		clear_scan();
		calm_now = 1'b0;
		bytes_in = 0;

		foreach (directed_rows[r]) begin
			n = (directed_rows[r].seg.len() == 0) ? 1 : directed_rows[r].seg.len();
			for (int i = 0; i < n; i++) begin
				item.data  = (directed_rows[r].seg.len() == 0) ? directed_rows[r].raw :
					directed_rows[r].seg[i];
				item.nf    = (i == 0) && directed_rows[r].nf;
				item.calm  = 1'b0;
				item.typed = directed_rows[r].typed && (i == n - 1);
				item.want  = directed_rows[r].want;
				dump_q.insert(dump_q.size(), item);
			end
		end

		gen_count = 0;
		while (gen_count < RANDOM_ITEMS) begin
			gen_calm = ($urandom_range(0, 5) == 0);
			build_page();
		end
		gen_calm = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (dump_q.size() != 0) begin
			item = dump_q.pop_front();
			gap = item.calm ? 0 : $urandom_range(0, 18);
			if (gap != 0) begin
				dump_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			dump_ch.valid <= 1'b1;
			dump_ch.text_byte <= item.data;
			dump_ch.new_file <= item.nf;
			calm_now = item.calm;
			do @(posedge clk); while (!dump_ch.ready);
			bytes_in++;
			extract_step(item.data, item.nf, fire, rec);
			if (item.typed) pending_results.insert(pending_results.size(), item.want);
			else if (fire) pending_results.insert(pending_results.size(), rec);
		end
		dump_ch.valid <= 1'b0;
		calm_now = 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d dump bytes with random gaps and result stalls.", bytes_in);
		$display("Checked %0d titles (longest %0d bytes), %0d links, %0d page ends.",
			titles_seen, longest_title, links_seen, ends_seen);
		if (fault_count == 0) begin
			$display("wiki_dump_link_extractor test passed");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("wiki_dump_link_extractor test failed");
		end
		$finish;
	end

endmodule

### sim.f
src/wdle_pkg.sv
src/wdle_dump_if.sv
src/wdle_result_if.sv
src/wdle_queue.sv
src/wdle_front.sv
src/wdle_back.sv
src/wiki_dump_link_extractor.sv
tb/tb_wiki_dump_link_extractor.sv
